FILE: src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the PCA texture bilinear sampler
// Store geometry, operation and register codes, the store write bundle and the
// signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Texture and basis geometry
	localparam int TEX_RES      = 64;
	localparam int NBASES       = 8;
	localparam int MAX_CHANNELS = 64;

	// Store depths
	localparam int TEXEL_DEPTH = 32768;
	localparam int COEFF_DEPTH = 512;
	localparam int MEAN_DEPTH  = 64;

	// Texel and coefficient stores are kept as NBASES lanes side by side (bytes for texels)
	localparam int LANE_W      = $clog2(NBASES);
	localparam int TEX_WORDS   = TEXEL_DEPTH / NBASES;
	localparam int TEX_AW      = $clog2(TEX_WORDS);
	localparam int COEFF_WORDS = COEFF_DEPTH / NBASES;
	localparam int COEFF_AW    = $clog2(COEFF_WORDS);
	localparam int MEAN_AW     = $clog2(MEAN_DEPTH);

	// Port widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 15;
	localparam int DATA_W  = 32;
	localparam int COORD_W = 17;
	localparam int CH_W    = 6;
	localparam int TINT_W  = 17;
	localparam int CHU_W   = 7;
	localparam int CFG_IDX_W = 3;

	// Coordinate arithmetic
	localparam int ONE_Q16 = 65536;
	localparam int IDX_W   = $clog2(TEX_RES);
	localparam int SU_W    = COORD_W + IDX_W + 1;
	localparam int IR_W    = SU_W - 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TEXEL  = 2'd0;
	localparam logic [OP_W-1:0] OP_COEFF  = 2'd1;
	localparam logic [OP_W-1:0] OP_MEAN   = 2'd2;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_R   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_G   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TINT_B   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 3'd5;

	// Store write bundle from the command port to the stores
	typedef struct packed {
		logic              tex_we;
		logic              coeff_we;
		logic              mean_we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} pts_wr_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

FILE: src/pts_recon.sv
// ----------------------------------------------------------------------------
// pts_recon: basis stores and texel reconstruction pipeline
// Holds the texel, coefficient and mean memories and turns one fetched texel
// word into a reconstructed pixel value through a registered pipeline.
// ----------------------------------------------------------------------------
module pts_recon (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pts_pkg::pts_wr_t                wr,
	input  logic                            row_rd,
	input  logic [pts_pkg::CH_W-1:0]        row_ch,
	input  logic                            fetch,
	input  logic [pts_pkg::TEX_AW-1:0]      fetch_word,
	input  logic signed [31:0]              dequant_step,
	input  logic signed [31:0]              dequant_offset,
	output logic                            pix_valid,
	output logic signed [31:0]              pix
);

	localparam int NB    = pts_pkg::NBASES;
	localparam int NPAIR = NB / 2;

	logic [7:0]  tex_mem   [NB][pts_pkg::TEX_WORDS];
	logic [31:0] coeff_mem [NB][pts_pkg::COEFF_WORDS];
	logic [31:0] mean_mem  [pts_pkg::MEAN_DEPTH];

	logic [7:0]         tex_s1   [NB];
	logic signed [31:0] coeff_q  [NB];
	logic signed [31:0] mean_q;
	logic signed [31:0] d_s2     [NB];
	logic signed [47:0] prod_s3  [NB];
	logic signed [48:0] pair_s4  [NPAIR];
	logic signed [31:0] pix_s5;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [63:0] total;

	always_ff @(posedge clk) begin
		if (wr.mean_we) begin
			mean_mem[wr.addr[pts_pkg::MEAN_AW-1:0]] <= wr.data;
		end
		if (row_rd) begin
			mean_q <= mean_mem[row_ch[pts_pkg::MEAN_AW-1:0]];
		end
	end

	for (genvar b = 0; b < NB; b++) begin : g_lane
		logic signed [40:0] dq_prod;
		logic signed [41:0] dq_sum;
		logic signed [63:0] cd_prod;

		always_ff @(posedge clk) begin
			if (wr.tex_we && wr.addr[pts_pkg::LANE_W-1:0] == pts_pkg::LANE_W'(b)) begin
				tex_mem[b][wr.addr[pts_pkg::LANE_W+pts_pkg::TEX_AW-1:pts_pkg::LANE_W]] <=
					wr.data[7:0];
			end
			if (fetch) begin
				tex_s1[b] <= tex_mem[b][fetch_word];
			end
		end

		always_ff @(posedge clk) begin
			if (wr.coeff_we && wr.addr[pts_pkg::LANE_W-1:0] == pts_pkg::LANE_W'(b)) begin
				coeff_mem[b][wr.addr[pts_pkg::LANE_W+pts_pkg::COEFF_AW-1:pts_pkg::LANE_W]] <=
					wr.data;
			end
			if (row_rd) begin
				coeff_q[b] <= coeff_mem[b][row_ch[pts_pkg::COEFF_AW-1:0]];
			end
		end

		// dequantize: byte * step + offset, saturated
		assign dq_prod = $signed({1'b0, tex_s1[b]}) * dequant_step;
		assign dq_sum  = {dq_prod[40], dq_prod} + {{10{dequant_offset[31]}}, dequant_offset};
		assign cd_prod = coeff_q[b] * d_s2[b];

		always_ff @(posedge clk) begin
			d_s2[b]    <= pts_pkg::sat32({{22{dq_sum[41]}}, dq_sum});
			prod_s3[b] <= cd_prod[63:16];
		end
	end

	for (genvar j = 0; j < NPAIR; j++) begin : g_pair
		always_ff @(posedge clk) begin
			pair_s4[j] <= {prod_s3[2*j][47], prod_s3[2*j]} +
				{prod_s3[2*j+1][47], prod_s3[2*j+1]};
		end
	end

	always_comb begin
		total = {{32{mean_q[31]}}, mean_q};
		for (int j = 0; j < NPAIR; j++) begin
			total = total + {{15{pair_s4[j][48]}}, pair_s4[j]};
		end
	end

	always_ff @(posedge clk) begin
		pix_s5 <= pts_pkg::sat32(total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= fetch;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign pix_valid = v_s5;
	assign pix       = pix_s5;

endmodule

FILE: src/pca_texture_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// pca_texture_bilinear_sampler: bilinear sampler of a PCA-compressed texture
// Loads texel bytes, coefficients and means, and returns tinted bilinear
// samples of one reconstruction channel in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive op, addr, wdata, u_coord, v_coord and channel with
//   start high; the transaction is taken at a clock edge where busy is low.
//   Store writes (texel byte, coefficient, mean) complete when taken and
//   return nothing; the next command may follow in the very next cycle.
//   A sample reads the coefficient row and mean of its channel when taken, then
//   fetches the four neighbouring texel words one per cycle from the texel
//   memory (NBASES bytes side by side per word), reconstructs them through a
//   five-stage pipeline and blends and tints the result.
//   A good sample keeps busy high from the edge that takes it to the edge
//   that raises done, so the next command can only be taken once busy has
//   fallen. The time is set by the four serial texel fetches plus the
//   reconstruct, blend and tint pipeline. An invalid channel strobes done
//   the next cycle with zero colours and bad_channel set, and keeps busy low.
//   Result channel: red, green, blue and bad_channel are valid while done is
//   high, for one cycle only; the receiver cannot stall and must take them.
//   Configuration: cfg_we, cfg_index and cfg_wdata write a register at once;
//   write only while no sample is in flight.
//   Reset clears the control state and loads the register defaults; the stores
//   hold no defined contents until written.
// ----------------------------------------------------------------------------
module pca_texture_bilinear_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [pts_pkg::OP_W-1:0]            op,
	input  logic [pts_pkg::ADDR_W-1:0]          addr,
	input  logic signed [pts_pkg::DATA_W-1:0]   wdata,
	input  logic [pts_pkg::COORD_W-1:0]         u_coord,
	input  logic [pts_pkg::COORD_W-1:0]         v_coord,
	input  logic [pts_pkg::CH_W-1:0]            channel,
	output logic                                done,
	output logic signed [31:0]                  red,
	output logic signed [31:0]                  green,
	output logic signed [31:0]                  blue,
	output logic                                bad_channel,
	input  logic                                cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pts_pkg::DATA_W-1:0]          cfg_wdata
);

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] FETCH_FIRST = 5'd1;
	localparam logic [STEP_W-1:0] FETCH_LAST  = 5'd4;
	localparam logic [STEP_W-1:0] LAST_STEP   = 5'd18;
	localparam int IDX_W = pts_pkg::IDX_W;
	localparam int SU_W  = pts_pkg::SU_W;
	localparam int IR_W  = pts_pkg::IR_W;
	localparam int WF_W  = 2 * IDX_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;

	// Configuration registers
	logic signed [31:0]              offset_q;
	logic signed [31:0]              step_cfg_q;
	logic [pts_pkg::TINT_W-1:0]      tint_q [3];
	logic [pts_pkg::CHU_W-1:0]       chan_use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			step_cfg_q <= 32'sd257;
			tint_q[0]  <= pts_pkg::TINT_W'(pts_pkg::ONE_Q16);
			tint_q[1]  <= pts_pkg::TINT_W'(pts_pkg::ONE_Q16);
			tint_q[2]  <= pts_pkg::TINT_W'(pts_pkg::ONE_Q16);
			chan_use_q <= pts_pkg::CHU_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				pts_pkg::CFG_OFFSET:   offset_q   <= cfg_wdata;
				pts_pkg::CFG_STEP:     step_cfg_q <= cfg_wdata;
				pts_pkg::CFG_TINT_R:   tint_q[0]  <= cfg_wdata[pts_pkg::TINT_W-1:0];
				pts_pkg::CFG_TINT_G:   tint_q[1]  <= cfg_wdata[pts_pkg::TINT_W-1:0];
				pts_pkg::CFG_TINT_B:   tint_q[2]  <= cfg_wdata[pts_pkg::TINT_W-1:0];
				pts_pkg::CFG_CHANNELS: chan_use_q <= cfg_wdata[pts_pkg::CHU_W-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Command decode
	logic accept, is_sample, ch_bad, good_sample;
	assign busy        = (state_q == ST_RUN);
	assign accept      = start && !busy;
	assign is_sample   = (op == pts_pkg::OP_SAMPLE);
	assign ch_bad      = ({1'b0, channel} >= chan_use_q) ||
		({3'b000, channel} >= 9'(pts_pkg::MAX_CHANNELS));
	assign good_sample = accept && is_sample && !ch_bad;

	pts_pkg::pts_wr_t wr;
	always_comb begin
		wr.tex_we   = accept && (op == pts_pkg::OP_TEXEL);
		wr.coeff_we = accept && (op == pts_pkg::OP_COEFF);
		wr.mean_we  = accept && (op == pts_pkg::OP_MEAN);
		wr.addr     = addr;
		wr.data     = wdata;
	end

	// Coordinate setup: saturate to one, split into texel index and weight
	logic [pts_pkg::COORD_W-1:0] u_sat, v_sat;
	logic [SU_W-1:0]  su, sv, wu_full, wv_full;
	logic [IR_W-1:0]  iu_raw, iv_raw;
	logic [IDX_W-1:0] iu_c, iuhi_c, iv_c;
	logic             u_edge;

	always_comb begin
		u_sat  = (u_coord > pts_pkg::COORD_W'(pts_pkg::ONE_Q16)) ?
			pts_pkg::COORD_W'(pts_pkg::ONE_Q16) : u_coord;
		v_sat  = (v_coord > pts_pkg::COORD_W'(pts_pkg::ONE_Q16)) ?
			pts_pkg::COORD_W'(pts_pkg::ONE_Q16) : v_coord;
		su     = SU_W'(u_sat) * SU_W'(pts_pkg::TEX_RES);
		sv     = SU_W'(v_sat) * SU_W'(pts_pkg::TEX_RES - 1);
		iu_raw = su[SU_W-1:16];
		iv_raw = sv[SU_W-1:16];
		// wrap the upper column to zero at the right edge
		u_edge = (iu_raw >= IR_W'(pts_pkg::TEX_RES - 1));
		if (u_edge) begin
			iu_c   = IDX_W'(pts_pkg::TEX_RES - 1);
			iuhi_c = '0;
		end else begin
			iu_c   = iu_raw[IDX_W-1:0];
			iuhi_c = iu_raw[IDX_W-1:0] + IDX_W'(1);
		end
		// clamp the lower row so that row + 1 stays inside
		if (iv_raw > IR_W'(pts_pkg::TEX_RES - 2)) begin
			iv_c = IDX_W'(pts_pkg::TEX_RES - 2);
		end else begin
			iv_c = iv_raw[IDX_W-1:0];
		end
		wu_full = su - {IR_W'(iu_c), 16'h0000};
		wv_full = sv - {IR_W'(iv_c), 16'h0000};
	end

	logic [IDX_W-1:0]  iu_q, iuhi_q, iv_q;
	logic [16:0]       wu_q, wv_q;

	always_ff @(posedge clk) begin
		if (good_sample) begin
			iu_q   <= iu_c;
			iuhi_q <= iuhi_c;
			iv_q   <= iv_c;
			wu_q   <= wu_full[16:0];
			wv_q   <= wv_full[16:0];
		end
	end

	// Sequencer: one texel word per cycle for the first four steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (good_sample) begin
						state_q <= ST_RUN;
						step_q  <= FETCH_FIRST;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_IDLE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	logic                       fetch;
	logic [1:0]                 fetch_k;
	logic [IDX_W-1:0]           fx, fy;
	logic [WF_W-1:0]            word_full;
	logic [pts_pkg::TEX_AW-1:0] fetch_word;

	// fetch order: (iu,iv) (iu+1,iv) (iu,iv+1) (iu+1,iv+1)
	always_comb begin
		fetch      = busy && (step_q >= FETCH_FIRST) && (step_q <= FETCH_LAST);
		fetch_k    = 2'(step_q - FETCH_FIRST);
		fx         = fetch_k[0] ? iuhi_q : iu_q;
		fy         = fetch_k[1] ? (iv_q + IDX_W'(1)) : iv_q;
		word_full  = WF_W'(fy) * WF_W'(pts_pkg::TEX_RES) + WF_W'(fx);
		fetch_word = word_full[pts_pkg::TEX_AW-1:0];
	end

	logic               pix_valid;
	logic signed [31:0] pix;

	pts_recon u_recon (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (wr),
		.row_rd         (good_sample),
		.row_ch         (channel),
		.fetch          (fetch),
		.fetch_word     (fetch_word),
		.dequant_step   (step_cfg_q),
		.dequant_offset (offset_q),
		.pix_valid      (pix_valid),
		.pix            (pix)
	);

	// Collect the four pixels in fetch order
	logic signed [31:0] p_q [4];
	always_ff @(posedge clk) begin
		if (pix_valid) begin
			p_q[0] <= p_q[1];
			p_q[1] <= p_q[2];
			p_q[2] <= p_q[3];
			p_q[3] <= pix;
		end
	end

	// Horizontal blend, then vertical; floor shifts take the upper bits
	logic signed [17:0] wu_hi, wu_lo, wv_hi, wv_lo;
	assign wu_hi = $signed({1'b0, wu_q});
	assign wu_lo = $signed({1'b0, 17'(pts_pkg::ONE_Q16) - wu_q});
	assign wv_hi = $signed({1'b0, wv_q});
	assign wv_lo = $signed({1'b0, 17'(pts_pkg::ONE_Q16) - wv_q});

	logic signed [49:0] hp_s1 [4];
	logic signed [31:0] top_s2, bot_s2;
	logic signed [49:0] vp_s3 [2];
	logic signed [31:0] lum_s4;
	logic signed [50:0] top_sum, bot_sum, lum_sum;

	assign top_sum = {hp_s1[0][49], hp_s1[0]} + {hp_s1[1][49], hp_s1[1]};
	assign bot_sum = {hp_s1[2][49], hp_s1[2]} + {hp_s1[3][49], hp_s1[3]};
	assign lum_sum = {vp_s3[0][49], vp_s3[0]} + {vp_s3[1][49], vp_s3[1]};

	always_ff @(posedge clk) begin
		hp_s1[0] <= p_q[0] * wu_lo;
		hp_s1[1] <= p_q[1] * wu_hi;
		hp_s1[2] <= p_q[2] * wu_lo;
		hp_s1[3] <= p_q[3] * wu_hi;
		top_s2   <= top_sum[47:16];
		bot_s2   <= bot_sum[47:16];
		vp_s3[0] <= top_s2 * wv_lo;
		vp_s3[1] <= bot_s2 * wv_hi;
		lum_s4   <= lum_sum[47:16];
	end

	// Tint: floor(lum * tint / 65536) then floor divide by 255.
	// Negative values divide their magnitude rounded up; the quotient of 255
	// is a shift series estimate plus a small remainder correction.
	logic signed [49:0] tp_s5  [3];
	logic [34:0]        n_s6   [3];
	logic               neg_s6 [3];
	logic [34:0]        n_s7   [3];
	logic [26:0]        qe_s7  [3];
	logic               neg_s7 [3];
	logic [10:0]        r_s8   [3];
	logic [26:0]        qe_s8  [3];
	logic               neg_s8 [3];
	logic signed [31:0] col    [3];

	for (genvar c = 0; c < 3; c++) begin : g_tint
		logic signed [33:0] y;
		logic [34:0]        n_c;
		logic [34:0]        r_full;
		logic [10:0]        r_fix;
		logic [26:0]        q_c;

		assign y      = tp_s5[c][49:16];
		assign n_c    = y[33] ? (35'd0 - {y[33], y} + 35'd254) : {1'b0, y};
		assign r_full = n_s7[c] - {qe_s7[c], 8'h00} + 35'(qe_s7[c]);
		assign r_fix  = (r_s8[c] + {3'b000, r_s8[c][10:8]} + 11'd1) >> 8;
		assign q_c    = qe_s8[c] + 27'(r_fix);
		assign col[c] = neg_s8[c] ? (32'sd0 - 32'(q_c)) : 32'(q_c);

		always_ff @(posedge clk) begin
			tp_s5[c]  <= lum_s4 * $signed({1'b0, tint_q[c]});
			n_s6[c]   <= n_c;
			neg_s6[c] <= y[33];
			n_s7[c]   <= n_s6[c];
			neg_s7[c] <= neg_s6[c];
			qe_s7[c]  <= 27'(n_s6[c] >> 8) + 27'(n_s6[c] >> 16) +
				27'(n_s6[c] >> 24) + 27'(n_s6[c] >> 32);
			r_s8[c]   <= r_full[10:0];
			qe_s8[c]  <= qe_s7[c];
			neg_s8[c] <= neg_s7[c];
		end
	end

	// Result register: bad channel answers at once, a sample at its last step
	logic               done_q, bad_q;
	logic signed [31:0] red_q, green_q, blue_q;
	logic               finish, bad_now;

	assign finish  = busy && (step_q == LAST_STEP);
	assign bad_now = accept && is_sample && ch_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish || bad_now;
		end
	end

	always_ff @(posedge clk) begin
		if (bad_now) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			bad_q   <= 1'b1;
		end else if (finish) begin
			red_q   <= col[0];
			green_q <= col[1];
			blue_q  <= col[2];
			bad_q   <= 1'b0;
		end
	end

	assign done        = done_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign bad_channel = bad_q;

endmodule

FILE: src/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the PCA texture bilinear sampler
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module pts_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [pts_pkg::OP_W-1:0]      op,
	input logic                          done,
	input logic signed [31:0]            red,
	input logic signed [31:0]            green,
	input logic signed [31:0]            blue,
	input logic                          bad_channel
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_busy_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transaction");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sample ended without a result");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_channel) |-> (red == 0 && green == 0 && blue == 0))
		else $error("bad channel result carries colour");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != pts_pkg::OP_SAMPLE) |=> !done)
		else $error("store write produced a result");

endmodule

bind pca_texture_bilinear_sampler pts_checker u_pts_checker (.*);

FILE: dv/pca_texture_bilinear_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pca_texture_bilinear_sampler_tb: self-checking bench of the PCA texture sampler
// Loads the coefficient and mean stores and the texel words of the border rows
// and columns, then runs directed and random commands over several register
// settings with samples kept on those texels. A local color predictor tracks
// the stores and registers; each done strobe is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module pca_texture_bilinear_sampler_tb;
	import pts_pkg::*;

	localparam int  PHASES     = 6;
	localparam int  RAND_ITEMS = 120;
	localparam int  SETTLE     = 25;      // a little over the sample latency
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic [ADDR_W-1:0]        addr;
		logic [DATA_W-1:0]        wdata;
		logic [COORD_W-1:0]       u;
		logic [COORD_W-1:0]       v;
		logic [CH_W-1:0]          ch;
	} cmd_t;

	typedef struct {
		logic [31:0] red;
		logic [31:0] green;
		logic [31:0] blue;
		logic        bad;
	} color_t;

	logic clk, arst_n;
	logic start, busy, done, bad_channel;
	logic [OP_W-1:0] op;
	logic [ADDR_W-1:0] addr;
	logic signed [DATA_W-1:0] wdata;
	logic [COORD_W-1:0] u_coord, v_coord;
	logic [CH_W-1:0] channel;
	logic signed [31:0] red, green, blue;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	pca_texture_bilinear_sampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .addr(addr), .wdata(wdata), .u_coord(u_coord), .v_coord(v_coord),
		.channel(channel), .done(done), .red(red), .green(green), .blue(blue),
		.bad_channel(bad_channel), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor copy of the stores and registers
	logic [7:0]  tex_mem [TEXEL_DEPTH];
	logic [31:0] coeff_mem [COEFF_DEPTH];
	logic [31:0] mean_mem [MEAN_DEPTH];
	logic [31:0] deq_offset, deq_step;
	logic [16:0] tint_r, tint_g, tint_b;
	logic [6:0]  chan_limit;

	cmd_t   cmd_q[$];
	color_t color_q[$];
	int     mismatches;
	longint cycles;
	logic   cmd_taken;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint sat32s(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Reconstruct one texel of a channel from the basis bytes
	function automatic longint texel_value(int x, int y, int ch);
		longint acc, bytev, deq, coef;
		int base;
		acc = 0;
		base = (y * TEX_RES + x) * NBASES;
		for (int b = 0; b < NBASES; b++) begin
			bytev = longint'(tex_mem[(base + b) % TEXEL_DEPTH]);
			deq = sat32s(bytev * longint'($signed(deq_step)) + longint'($signed(deq_offset)));
			coef = longint'($signed(coeff_mem[(ch * NBASES + b) % COEFF_DEPTH]));
			acc += (coef * deq) >>> 16;
		end
		acc += longint'($signed(mean_mem[ch % MEAN_DEPTH]));
		return sat32s(acc);
	endfunction

	function automatic longint lerp_q16(longint a, longint b, longint w);
		return (a * (65536 - w) + b * w) >>> 16;
	endfunction

	function automatic logic [31:0] apply_tint(longint lum, logic [16:0] tint);
		longint p, d, q;
		d = 255 * 65536;
		p = lum * longint'(tint);
		q = (p >= 0) ? p / d : -((-p + d - 1) / d);
		return 32'(sat32s(q));
	endfunction

	function automatic color_t predict_color(logic [16:0] u_in, logic [16:0] v_in,
	                                         logic [5:0] ch);
		color_t r;
		longint su, sv, wu, wv, top, bot, lum;
		int iu, iu_hi, iv;
		r.bad = 1'b0;
		if (ch >= chan_limit || ch >= MAX_CHANNELS) begin
			r = '{32'd0, 32'd0, 32'd0, 1'b1};
			return r;
		end
		su = (u_in > ONE_Q16 ? ONE_Q16 : longint'(u_in)) * TEX_RES;
		sv = (v_in > ONE_Q16 ? ONE_Q16 : longint'(v_in)) * (TEX_RES - 1);
		iu = int'(su >> 16);
		// the column past the right edge wraps to column 0
		if (iu >= TEX_RES - 1) begin
			iu = TEX_RES - 1;
			iu_hi = 0;
		end else begin
			iu_hi = iu + 1;
		end
		wu = su - (longint'(iu) << 16);
		// clamp v so that row iv+1 stays inside the texture
		iv = int'(sv >> 16);
		if (iv > TEX_RES - 2) iv = TEX_RES - 2;
		wv = sv - (longint'(iv) << 16);
		top = lerp_q16(texel_value(iu, iv, ch), texel_value(iu_hi, iv, ch), wu);
		bot = lerp_q16(texel_value(iu, iv + 1, ch), texel_value(iu_hi, iv + 1, ch), wu);
		lum = lerp_q16(top, bot, wv);
		r.red = apply_tint(lum, tint_r);
		r.green = apply_tint(lum, tint_g);
		r.blue = apply_tint(lum, tint_b);
		return r;
	endfunction

	// Monitor: check results, then log the transaction taken at this edge
	always @(posedge clk) begin
		color_t exp_c;
		cmd_taken = arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (color_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("done strobe with no sample pending at %0t", $realtime);
				end else begin
					exp_c = color_q.pop_front();
					if (red !== exp_c.red || green !== exp_c.green || blue !== exp_c.blue ||
					    bad_channel !== exp_c.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch at %0t: exp r=%h g=%h b=%h bad=%b ",
							          "got r=%h g=%h b=%h bad=%b"},
							         $realtime, exp_c.red, exp_c.green, exp_c.blue, exp_c.bad,
							         red, green, blue, bad_channel);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OFFSET:   deq_offset <= cfg_wdata;
					CFG_STEP:     deq_step <= cfg_wdata;
					CFG_TINT_R:   tint_r <= cfg_wdata[16:0];
					CFG_TINT_G:   tint_g <= cfg_wdata[16:0];
					CFG_TINT_B:   tint_b <= cfg_wdata[16:0];
					CFG_CHANNELS: chan_limit <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (op)
					OP_TEXEL:  tex_mem[addr % TEXEL_DEPTH] = wdata[7:0];
					OP_COEFF:  coeff_mem[addr % COEFF_DEPTH] = wdata;
					OP_MEAN:   mean_mem[addr % MEAN_DEPTH] = wdata;
					OP_SAMPLE: color_q.push_back(predict_color(u_coord, v_coord, channel));
					default: ;
				endcase
			end
		end
	end

	// Driver: bursts of commands with random gaps, changes on the falling edge
	always @(negedge clk) begin
		static int burst_left = 0;
		static int gap_left = 0;
		cmd_t c;
		if (arst_n) begin
			if (start && !cmd_taken) begin
				// hold the transaction until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				c = cmd_q.pop_front();
				op <= c.op; addr <= c.addr; wdata <= c.wdata;
				u_coord <= c.u; v_coord <= c.v; channel <= c.ch;
				start <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
				end else if (--burst_left == 0) begin
					// some bursts run long, some are followed by a pause
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_cmd(logic [OP_W-1:0] o, logic [ADDR_W-1:0] a, logic [31:0] d,
	                        logic [16:0] u, logic [16:0] v, logic [5:0] ch);
		cmd_q.push_back('{o, a, d, u, v, ch});
	endtask

	task automatic push_sample(logic [16:0] u, logic [16:0] v, logic [5:0] ch);
		push_cmd(OP_SAMPLE, ADDR_W'($urandom), $urandom, u, v, ch);
	endtask

	// Loaded rows and columns: the first four and the last four
	function automatic int border_idx(int k);
		return (k < 4) ? k : (TEX_RES - 8 + k);
	endfunction

	// Coordinates that only touch the loaded border texels
	function automatic logic [16:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'd65535;
			3: return 17'($urandom_range(65537, 131071));
			default: return ($urandom_range(0, 1) != 0) ? 17'($urandom_range(0, 3000)) :
			                17'($urandom_range(62500, 65536));
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		// mostly modest Q16.16 values, now and then anything at all
		if ($urandom_range(0, 4) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 262143)) - 131072);
	endfunction

	task automatic push_random(int n);
		logic [OP_W-1:0] o;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1)) begin
				push_sample(pick_coord(), pick_coord(), 6'($urandom));
			end else begin
				o = OP_W'($urandom_range(0, 2));
				push_cmd(o, ADDR_W'($urandom), (o == OP_TEXEL) ? $urandom : pick_word(),
				         17'($urandom), 17'($urandom), 6'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		while (cmd_q.size() > 0 || start || color_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(logic [31:0] off, logic [31:0] stp, logic [16:0] tr,
	                              logic [16:0] tg, logic [16:0] tb, logic [6:0] chu);
		write_reg(CFG_OFFSET, off);
		write_reg(CFG_STEP, stp);
		write_reg(CFG_TINT_R, 32'(tr));
		write_reg(CFG_TINT_G, 32'(tg));
		write_reg(CFG_TINT_B, 32'(tb));
		write_reg(CFG_CHANNELS, 32'(chu));
	endtask

	initial begin
		mismatches = 0; cycles = 0; cmd_taken = 1'b0;
		start = 1'b0; op = OP_TEXEL; addr = '0; wdata = '0;
		u_coord = '0; v_coord = '0; channel = '0;
		cfg_we = 1'b0; cfg_index = CFG_OFFSET; cfg_wdata = '0;
		deq_offset = 32'd0; deq_step = 32'd257;
		tint_r = 17'd65536; tint_g = 17'd65536; tint_b = 17'd65536;
		chan_limit = 7'd64;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load the border texel words and every coefficient and mean, so that
		// no sample ever reads an unwritten entry
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++)
				for (int b = 0; b < NBASES; b++)
					push_cmd(OP_TEXEL,
					         ADDR_W'((border_idx(r) * TEX_RES + border_idx(c)) * NBASES + b),
					         $urandom, 0, 0, 0);
		for (int i = 0; i < COEFF_DEPTH; i++) push_cmd(OP_COEFF, ADDR_W'(i), pick_word(), 0, 0, 0);
		for (int i = 0; i < MEAN_DEPTH; i++) push_cmd(OP_MEAN, ADDR_W'(i), pick_word(), 0, 0, 0);

		// Directed: field extremes, address wrap, coordinate corners and overrange
		push_cmd(OP_TEXEL, 15'h7FFF, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 6'h3F);
		push_cmd(OP_TEXEL, 15'h0000, 32'h0000_0000, 0, 0, 0);
		push_cmd(OP_COEFF, 15'h7FFF, 32'h8000_0000, 0, 0, 0);
		push_cmd(OP_COEFF, 15'h01F8, 32'h7FFF_FFFF, 0, 0, 0);
		push_cmd(OP_MEAN, 15'h7FFF, 32'h7FFF_FFFF, 0, 0, 0);
		push_cmd(OP_MEAN, 15'h0040, 32'h8000_0000, 0, 0, 0);
		push_sample(17'd0, 17'd0, 6'd0);
		push_sample(17'd65536, 17'd65536, 6'd63);
		push_sample(17'd65535, 17'd65535, 6'd0);
		push_sample(17'h1FFFF, 17'h1FFFF, 6'd63);
		push_sample(17'd65536, 17'd0, 6'd1);
		push_sample(17'd0, 17'd65536, 6'd62);
		push_sample(17'd3000, 17'd62500, 6'd31);
		push_sample(17'd1023, 17'd1041, 6'd5);
		push_random(RAND_ITEMS);
		wait_idle();

		for (int ph = 1; ph < PHASES; ph++) begin
			case (ph)
				1: write_all_regs(32'h8000_0000, 32'h7FFF_FFFF, 17'd0, 17'd65536, 17'h1FFFF, 7'd64);
				2: write_all_regs(32'h7FFF_FFFF, 32'h8000_0000, 17'd65536, 17'd0, 17'd1, 7'd0);
				3: write_all_regs(-32'sd65536, 32'd4096, 17'($urandom_range(0, 65536)),
				                  17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
				                  7'd127);
				4: write_all_regs(32'($urandom_range(0, 131072)) - 32'd65536,
				                  32'($urandom_range(0, 2048)), 17'd65536, 17'd32768,
				                  17'd12345, 7'd20);
				default: write_all_regs($urandom, $urandom, 17'($urandom), 17'($urandom),
				                        17'($urandom), 7'($urandom));
			endcase
			if (ph == 2) begin
				// no channel is valid here: every sample must be flagged
				push_sample(17'd0, 17'd0, 6'd0);
				push_sample(17'd65536, 17'd65536, 6'd63);
			end
			if (ph == 4) begin
				// first channel past the limit and the last one inside it
				push_sample(17'd2000, 17'd63000, 6'd20);
				push_sample(17'd2000, 17'd63000, 6'd19);
			end
			push_random(RAND_ITEMS);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/pts_pkg.sv
src/pts_recon.sv
src/pca_texture_bilinear_sampler.sv
src/pts_checker.sv
dv/pca_texture_bilinear_sampler_tb.sv
